### hdl/grw_pkg.sv
// ----------------------------------------------------------------------------
// grw_pkg
// Shared types and constants for the grid ray cell walker.
// ----------------------------------------------------------------------------
package grw_pkg;

    // field and datapath widths
    localparam int CW    = 32;   // coordinate input width, Q23.8
    localparam int IDXW  = 20;   // cell index width
    localparam int CSW   = 16;   // cell size register width
    localparam int CNW   = 11;   // cell count register width
    localparam int QW    = 23;   // divider dividend / quotient magnitude
    localparam int SIDEW = 24;   // cell side in Q8
    localparam int CRDW  = 25;   // signed cell coordinate
    localparam int GAPW  = 30;   // running distance to next boundary
    localparam int DW    = 33;   // absolute delta
    localparam int PW    = 62;   // cross products
    localparam int MCW   = 6;    // multiply step counter
    localparam int DCW   = 5;    // divide step counter
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [MCW-1:0] MUL_STEPS = MCW'(DW);
    localparam logic [DCW-1:0] DIV_STEPS = DCW'(QW);

    // register reset values
    localparam logic [CSW-1:0] CELL_SIZE_RST    = 16'd4096;
    localparam logic [CNW-1:0] CELLS_ACROSS_RST = 11'd64;
    localparam logic [CNW-1:0] CELLS_DOWN_RST   = 11'd64;

    localparam int MAX_CELLS_DEF = 20;

    // register indexes
    localparam logic [1:0] REG_CELL_SIZE    = 2'd0;
    localparam logic [1:0] REG_CELLS_ACROSS = 2'd1;
    localparam logic [1:0] REG_CELLS_DOWN   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SETUP,
        S_MUL,
        S_CALC,
        S_HOLD,
        S_STEP
    } state_t;

    typedef struct packed {
        logic start;   // latch segment, start dividers
        logic setup;   // latch cells and gaps, start products
        logic calc;    // load output register with current cell
        logic step;    // advance one cell
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic mul_busy;
        logic single;  // segment stays in its start cell
        logic last;    // loaded cell is the final one
    } status_t;

endpackage

### hdl/grw_if.sv
// ----------------------------------------------------------------------------
// grw_seg_if / grw_cell_if
// Valid/ready channels for segments in and visited cells out.
// ----------------------------------------------------------------------------
interface grw_seg_if;
    logic                          valid;
    logic                          ready;
    logic signed [grw_pkg::CW-1:0] start_x;
    logic signed [grw_pkg::CW-1:0] start_z;
    logic signed [grw_pkg::CW-1:0] end_x;
    logic signed [grw_pkg::CW-1:0] end_z;

    modport source (output valid, start_x, start_z, end_x, end_z, input ready);
    modport sink   (input valid, start_x, start_z, end_x, end_z, output ready);
endinterface

interface grw_cell_if;
    logic                     valid;
    logic                     ready;
    logic [grw_pkg::IDXW-1:0] cell_index;
    logic                     in_grid;
    logic                     last;

    modport source (output valid, cell_index, in_grid, last, input ready);
    modport sink   (input valid, cell_index, in_grid, last, output ready);
endinterface

### hdl/grw_div.sv
// ----------------------------------------------------------------------------
// grw_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grw_div
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [grw_pkg::QW-1:0]   dividend,
    input  logic [grw_pkg::CSW-1:0]  divisor,
    output logic [grw_pkg::QW-1:0]   quotient,
    output logic [grw_pkg::CSW-1:0]  remainder,
    output logic                     busy
);

    logic [grw_pkg::QW-1:0]  quo_reg, quo_next;
    logic [grw_pkg::CSW-1:0] rem_reg, rem_next;
    logic [grw_pkg::DCW-1:0] cnt_reg, cnt_next;
    logic [grw_pkg::CSW:0]   trial;
    logic                    ge;

    // one shift-subtract step
    always_comb
    begin
        trial    = {rem_reg, quo_reg[grw_pkg::QW-1]};
        ge       = trial >= {1'b0, divisor};
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = grw_pkg::DIV_STEPS;
        end
        else if (cnt_reg != '0)
        begin
            quo_next = {quo_reg[grw_pkg::QW-2:0], ge};
            rem_next = ge ? grw_pkg::CSW'(trial - {1'b0, divisor})
                          : grw_pkg::CSW'(trial);
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign busy      = cnt_reg != '0;

endmodule

### hdl/grw_ctrl.sv
// ----------------------------------------------------------------------------
// grw_ctrl
// Sequencer: divide, set up products, then emit one cell per pass.
// ----------------------------------------------------------------------------
module grw_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  grw_pkg::status_t  status,
    output grw_pkg::cmd_t     cmd
);

    grw_pkg::state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            grw_pkg::S_IDLE:  if (in_valid) state_next = grw_pkg::S_DIV;
            grw_pkg::S_DIV:   if (!status.div_busy) state_next = grw_pkg::S_SETUP;
            grw_pkg::S_SETUP: state_next = status.single ? grw_pkg::S_CALC : grw_pkg::S_MUL;
            grw_pkg::S_MUL:   if (!status.mul_busy) state_next = grw_pkg::S_CALC;
            grw_pkg::S_CALC:  state_next = grw_pkg::S_HOLD;
            grw_pkg::S_HOLD:
            begin
                if (out_ready)
                    state_next = status.last ? grw_pkg::S_IDLE : grw_pkg::S_STEP;
            end
            grw_pkg::S_STEP:  state_next = grw_pkg::S_CALC;
            default:          state_next = grw_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            grw_pkg::S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
            end
            grw_pkg::S_SETUP: cmd.setup = 1'b1;
            grw_pkg::S_CALC:  cmd.calc  = 1'b1;
            grw_pkg::S_HOLD:  out_valid = 1'b1;
            grw_pkg::S_STEP:  cmd.step  = 1'b1;
            default:          cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= grw_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/grw_datapath.sv
// ----------------------------------------------------------------------------
// grw_datapath
// Cell division, exact crossing products and the per-cell DDA step.
// ----------------------------------------------------------------------------
module grw_datapath
#(
    parameter int MAX_CELLS = grw_pkg::MAX_CELLS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  grw_pkg::cmd_t                 cmd,
    output grw_pkg::status_t              status,
    input  logic signed [grw_pkg::CW-1:0] start_x,
    input  logic signed [grw_pkg::CW-1:0] start_z,
    input  logic signed [grw_pkg::CW-1:0] end_x,
    input  logic signed [grw_pkg::CW-1:0] end_z,
    input  logic [grw_pkg::CSW-1:0]       cell_size,
    input  logic [grw_pkg::CNW-1:0]       cells_across,
    input  logic [grw_pkg::CNW-1:0]       cells_down,
    output logic [grw_pkg::IDXW-1:0]      cell_index,
    output logic                          in_grid,
    output logic                          last
);

    localparam int KW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam logic [KW-1:0] K_LAST = KW'(MAX_CELLS - 1);

    // segment held for the whole walk
    logic signed [grw_pkg::CW-1:0] sx_reg, sz_reg, ex_reg, ez_reg;

    logic [grw_pkg::CSW-1:0]   divisor;
    logic [grw_pkg::SIDEW-1:0] side;
    logic [grw_pkg::QW-1:0]    div_in   [4];
    logic [grw_pkg::QW-1:0]    div_quo  [4];
    logic [grw_pkg::CSW-1:0]   div_rem  [4];
    logic [3:0]                div_busy;
    logic [3:0]                in_neg;
    logic [3:0]                held_neg;
    logic signed [grw_pkg::CRDW-1:0] cell_of [4];
    logic [grw_pkg::CSW-1:0]   rem_fx, rem_fz;

    logic signed [grw_pkg::DW-1:0] dx, dz;
    logic [grw_pkg::DW-1:0]        adx, adz;
    logic [grw_pkg::SIDEW-1:0]     mx, mz, nx0, nz0;
    logic                          single_now;

    // walk state
    logic signed [grw_pkg::CRDW-1:0] cx_reg, cz_reg, gx_reg, gz_reg;
    logic [grw_pkg::GAPW-1:0]  nx_reg, nz_reg;
    logic [grw_pkg::DW-1:0]    adx_reg, adz_reg, shx_reg, shz_reg;
    logic                      xneg_reg, zneg_reg, single_reg;
    logic [grw_pkg::PW-1:0]    a_reg, b_reg, sa_reg, sb_reg;
    logic [grw_pkg::MCW-1:0]   mcnt_reg;
    logic [KW-1:0]             k_reg;

    logic                      step_x, beyond, at_end, on_grid, last_now;
    logic [2*grw_pkg::CNW-1:0] row_base;
    logic [grw_pkg::IDXW-1:0]  idx_now;

    logic [grw_pkg::IDXW-1:0]  idx_reg;
    logic                      in_grid_reg, last_reg;

    assign divisor = (cell_size == '0) ? grw_pkg::CSW'(1) : cell_size;
    assign side    = {divisor, 8'h00};

    // floor division of the whole-unit part: negative values divide their complement
    assign in_neg = {end_z[grw_pkg::CW-1], end_x[grw_pkg::CW-1],
                     start_z[grw_pkg::CW-1], start_x[grw_pkg::CW-1]};
    assign div_in[0] = in_neg[0] ? ~start_x[grw_pkg::CW-2:8] : start_x[grw_pkg::CW-2:8];
    assign div_in[1] = in_neg[1] ? ~start_z[grw_pkg::CW-2:8] : start_z[grw_pkg::CW-2:8];
    assign div_in[2] = in_neg[2] ? ~end_x[grw_pkg::CW-2:8]   : end_x[grw_pkg::CW-2:8];
    assign div_in[3] = in_neg[3] ? ~end_z[grw_pkg::CW-2:8]   : end_z[grw_pkg::CW-2:8];
    assign held_neg  = {ez_reg[grw_pkg::CW-1], ex_reg[grw_pkg::CW-1],
                        sz_reg[grw_pkg::CW-1], sx_reg[grw_pkg::CW-1]};

    for (genvar i = 0; i < 4; i++)
    begin : g_div
        grw_div u_div
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .start     (cmd.start),
            .dividend  (div_in[i]),
            .divisor   (divisor),
            .quotient  (div_quo[i]),
            .remainder (div_rem[i]),
            .busy      (div_busy[i])
        );
        assign cell_of[i] = held_neg[i] ? ~{2'b00, div_quo[i]} : {2'b00, div_quo[i]};
    end

    assign rem_fx = held_neg[0] ? grw_pkg::CSW'(divisor - div_rem[0] - 1'b1) : div_rem[0];
    assign rem_fz = held_neg[1] ? grw_pkg::CSW'(divisor - div_rem[1] - 1'b1) : div_rem[1];

    // deltas and first boundary gaps
    assign dx  = grw_pkg::DW'(ex_reg) - grw_pkg::DW'(sx_reg);
    assign dz  = grw_pkg::DW'(ez_reg) - grw_pkg::DW'(sz_reg);
    assign adx = dx[grw_pkg::DW-1] ? grw_pkg::DW'(-dx) : grw_pkg::DW'(dx);
    assign adz = dz[grw_pkg::DW-1] ? grw_pkg::DW'(-dz) : grw_pkg::DW'(dz);
    assign mx  = {rem_fx, sx_reg[7:0]};
    assign mz  = {rem_fz, sz_reg[7:0]};
    assign nx0 = dx[grw_pkg::DW-1] ? mx : side - mx;
    assign nz0 = dz[grw_pkg::DW-1] ? mz : side - mz;

    assign single_now = (cell_of[0] == cell_of[2] && cell_of[1] == cell_of[3])
                        || (dx == '0 && dz == '0);

    // choose the nearer crossing, ties go along z
    assign step_x   = a_reg < b_reg;
    assign beyond   = step_x ? (grw_pkg::DW'(nx_reg) > adx_reg)
                             : (grw_pkg::DW'(nz_reg) > adz_reg);
    assign at_end   = (cx_reg == gx_reg) && (cz_reg == gz_reg);
    assign last_now = single_reg || at_end || (k_reg == K_LAST) || beyond;

    // grid membership and row-major index
    assign on_grid  = !cx_reg[grw_pkg::CRDW-1] && !cz_reg[grw_pkg::CRDW-1]
                      && (cx_reg < grw_pkg::CRDW'(cells_across))
                      && (cz_reg < grw_pkg::CRDW'(cells_down));
    assign row_base = cz_reg[grw_pkg::CNW-1:0] * cells_across;
    assign idx_now  = grw_pkg::IDXW'(row_base + grw_pkg::IDXW'(cx_reg[grw_pkg::CNW-1:0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcnt_reg <= '0;
        end
        else if (cmd.setup)
        begin
            mcnt_reg <= grw_pkg::MUL_STEPS;
        end
        else if (mcnt_reg != '0)
        begin
            mcnt_reg <= mcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        // hold the segment
        if (cmd.start)
        begin
            sx_reg <= start_x;
            sz_reg <= start_z;
            ex_reg <= end_x;
            ez_reg <= end_z;
        end

        // latch cells and gaps, clear the products
        if (cmd.setup)
        begin
            cx_reg     <= cell_of[0];
            cz_reg     <= cell_of[1];
            gx_reg     <= cell_of[2];
            gz_reg     <= cell_of[3];
            nx_reg     <= grw_pkg::GAPW'(nx0);
            nz_reg     <= grw_pkg::GAPW'(nz0);
            adx_reg    <= adx;
            adz_reg    <= adz;
            shx_reg    <= adx;
            shz_reg    <= adz;
            xneg_reg   <= dx[grw_pkg::DW-1];
            zneg_reg   <= dz[grw_pkg::DW-1];
            single_reg <= single_now;
            k_reg      <= '0;
            a_reg      <= '0;
            b_reg      <= '0;
            sa_reg     <= '0;
            sb_reg     <= '0;
        end
        // shift-add products, one delta bit per cycle from the top
        else if (mcnt_reg != '0)
        begin
            shx_reg <= shx_reg << 1;
            shz_reg <= shz_reg << 1;
            a_reg  <= (a_reg << 1)
                      + (shz_reg[grw_pkg::DW-1] ? grw_pkg::PW'(nx_reg) : '0);
            b_reg  <= (b_reg << 1)
                      + (shx_reg[grw_pkg::DW-1] ? grw_pkg::PW'(nz_reg) : '0);
            sa_reg <= (sa_reg << 1)
                      + (shz_reg[grw_pkg::DW-1] ? grw_pkg::PW'(side) : '0);
            sb_reg <= (sb_reg << 1)
                      + (shx_reg[grw_pkg::DW-1] ? grw_pkg::PW'(side) : '0);
        end
        // advance one cell
        else if (cmd.step)
        begin
            k_reg <= k_reg + 1'b1;
            if (step_x)
            begin
                a_reg  <= a_reg + sa_reg;
                nx_reg <= nx_reg + grw_pkg::GAPW'(side);
                cx_reg <= xneg_reg ? cx_reg - 1'b1 : cx_reg + 1'b1;
            end
            else
            begin
                b_reg  <= b_reg + sb_reg;
                nz_reg <= nz_reg + grw_pkg::GAPW'(side);
                cz_reg <= zneg_reg ? cz_reg - 1'b1 : cz_reg + 1'b1;
            end
        end

        // load the output register
        if (cmd.calc)
        begin
            idx_reg     <= on_grid ? idx_now : '0;
            in_grid_reg <= on_grid;
            last_reg    <= last_now;
        end
    end

    assign status.div_busy = |div_busy;
    assign status.mul_busy = mcnt_reg != '0;
    assign status.single   = single_now;
    assign status.last     = last_reg;

    assign cell_index = idx_reg;
    assign in_grid    = in_grid_reg;
    assign last       = last_reg;

endmodule

### hdl/grid_ray_cell_walk_top.sv
// ----------------------------------------------------------------------------
// grid_ray_cell_walk_top
// Lists the grid cells crossed by a 2D segment, one item per cell.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                 transfer
//  seg      in   start_x, start_z, end_x, end_z (Q23.8)  valid & ready
//  visit    out  cell_index, in_grid, last               valid & ready
//  apb      in   cell_size, cells_across, cells_down     psel & penable & pwrite
//
//  A segment is accepted, passes the four parallel dividers (23 quotient
//  bits) and is set up; a walk of more than one cell then runs the
//  bit-serial crossing products (33 steps), and each cell passes the calc,
//  hold and step states, the final one without the step. A single-cell
//  segment skips the products. The divider and the shift-add products set
//  the setup time. One segment is in flight; seg.ready is low until its last
//  cell is taken. A stalled cell holds its item. Reset clears control and
//  restores the register defaults.
// ----------------------------------------------------------------------------
module grid_ray_cell_walk_top
#(
    parameter int MAX_CELLS = grw_pkg::MAX_CELLS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    grw_seg_if.sink                     seg,
    grw_cell_if.source                  visit,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [grw_pkg::APB_AW-1:0]  paddr,
    input  logic [grw_pkg::APB_DW-1:0]  pwdata,
    output logic [grw_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    logic [grw_pkg::CSW-1:0] cell_size_reg;
    logic [grw_pkg::CNW-1:0] cells_across_reg, cells_down_reg;
    logic                    wr_en;
    grw_pkg::cmd_t           cmd;
    grw_pkg::status_t        status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg    <= grw_pkg::CELL_SIZE_RST;
            cells_across_reg <= grw_pkg::CELLS_ACROSS_RST;
            cells_down_reg   <= grw_pkg::CELLS_DOWN_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                grw_pkg::REG_CELL_SIZE:    cell_size_reg    <= pwdata[grw_pkg::CSW-1:0];
                grw_pkg::REG_CELLS_ACROSS: cells_across_reg <= pwdata[grw_pkg::CNW-1:0];
                grw_pkg::REG_CELLS_DOWN:   cells_down_reg   <= pwdata[grw_pkg::CNW-1:0];
                default:                   cell_size_reg    <= cell_size_reg;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (paddr[3:2])
            grw_pkg::REG_CELL_SIZE:    prdata = grw_pkg::APB_DW'(cell_size_reg);
            grw_pkg::REG_CELLS_ACROSS: prdata = grw_pkg::APB_DW'(cells_across_reg);
            grw_pkg::REG_CELLS_DOWN:   prdata = grw_pkg::APB_DW'(cells_down_reg);
            default:                   prdata = '0;
        endcase
    end

    grw_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (seg.valid),
        .in_ready  (seg.ready),
        .out_valid (visit.valid),
        .out_ready (visit.ready),
        .status    (status),
        .cmd       (cmd)
    );

    grw_datapath #(.MAX_CELLS(MAX_CELLS)) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .start_x      (seg.start_x),
        .start_z      (seg.start_z),
        .end_x        (seg.end_x),
        .end_z        (seg.end_z),
        .cell_size    (cell_size_reg),
        .cells_across (cells_across_reg),
        .cells_down   (cells_down_reg),
        .cell_index   (visit.cell_index),
        .in_grid      (visit.in_grid),
        .last         (visit.last)
    );

endmodule

### hdl/grw_checker.sv
// ----------------------------------------------------------------------------
// grw_checker
// Port-level checks of the cell walker, bound to the top level.
// ----------------------------------------------------------------------------
module grw_checker
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     seg_valid,
    input logic                     seg_ready,
    input logic                     cell_valid,
    input logic                     cell_ready,
    input logic [grw_pkg::IDXW-1:0] cell_index,
    input logic                     cell_in_grid,
    input logic                     cell_last
);

    // a stalled cell stays offered
    a_cell_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && !cell_ready |=> cell_valid)
        else $error("cell item dropped while stalled");

    // no new segment while a cell is pending
    a_one_seg: assert property (@(posedge clk) disable iff (!rst_n)
        seg_ready |-> !cell_valid)
        else $error("segment taken while a cell is pending");

    // an accepted segment closes the input
    a_seg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && seg_ready |=> !seg_ready)
        else $error("input reopened straight after a segment");

    // more cells follow a non-final one
    a_more: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && cell_ready && !cell_last |=> !seg_ready)
        else $error("input reopened before the final cell");

    // off-grid cells carry index zero
    a_off_grid: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && !cell_in_grid |-> cell_index == '0)
        else $error("off-grid cell with nonzero index");

endmodule

bind grid_ray_cell_walk_top grw_checker u_grw_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .seg_valid    (seg.valid),
    .seg_ready    (seg.ready),
    .cell_valid   (visit.valid),
    .cell_ready   (visit.ready),
    .cell_index   (visit.cell_index),
    .cell_in_grid (visit.in_grid),
    .cell_last    (visit.last)
);

### tb/grw_walk_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grw_walk_checker
// Watches the segment and cell channels, works out the cells each accepted
// segment should visit and compares every cell item with the oldest one due.
// ----------------------------------------------------------------------------
module grw_walk_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    grw_seg_if.sink                      seg,
    grw_cell_if.sink                     visit,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [grw_pkg::APB_AW-1:0]   paddr,
    input  logic [grw_pkg::APB_DW-1:0]   pwdata,
    input  logic                         pready,
    output int                           fail_count,
    output int                           cells_due,
    output int                           cells_seen,
    output int                           walks_seen
);

    typedef struct packed {
        logic [grw_pkg::IDXW-1:0] idx;
        logic                     on_grid;
        logic                     fin;
    } visit_t;

    visit_t visits_due[$];

    logic [grw_pkg::CSW-1:0] side_units;
    logic [grw_pkg::CNW-1:0] across;
    logic [grw_pkg::CNW-1:0] down;

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q--;
        return q;
    endfunction

    function automatic visit_t place(longint cx, longint cz);
        visit_t v;
        v.on_grid = cx >= 0 && cz >= 0 && cx < longint'(across) && cz < longint'(down);
        v.idx     = v.on_grid ? grw_pkg::IDXW'(cz * longint'(across) + cx) : '0;
        v.fin     = 1'b0;
        return v;
    endfunction

    // Work out every cell of one segment, in visiting order
    task automatic plan_walk(longint sx, longint sz, longint ex, longint ez);
        longint side, cx, cz, gx, gz, dx, dz, stx, stz;
        longint unsigned adx, adz, nx, nz;
        bit beyond;
        int k;
        visit_t v;
        side = longint'(side_units == 0 ? 16'd1 : side_units) * 256;
        cx = floor_div(sx, side);
        cz = floor_div(sz, side);
        gx = floor_div(ex, side);
        gz = floor_div(ez, side);
        dx = ex - sx;
        dz = ez - sz;
        adx = dx < 0 ? -dx : dx;
        adz = dz < 0 ? -dz : dz;
        stx = dx > 0 ? 1 : -1;
        stz = dz > 0 ? 1 : -1;
        if ((cx == gx && cz == gz) || (dx == 0 && dz == 0))
        begin
            v = place(cx, cz);
            v.fin = 1'b1;
            visits_due = {visits_due, v};
            return;
        end
        nx = dx < 0 ? sx - cx * side : (cx + 1) * side - sx;
        nz = dz < 0 ? sz - cz * side : (cz + 1) * side - sz;
        k = 0;
        while (k < grw_pkg::MAX_CELLS_DEF)
        begin
            v = place(cx, cz);
            k++;
            if ((cx == gx && cz == gz) || k == grw_pkg::MAX_CELLS_DEF)
            begin
                v.fin = 1'b1;
                visits_due = {visits_due, v};
                break;
            end
            // ties go along z
            if (nx * adz < nz * adx)
            begin
                beyond = nx > adx;
                nx += side;
                cx += stx;
            end
            else
            begin
                beyond = nz > adz;
                nz += side;
                cz += stz;
            end
            v.fin = beyond;
            visits_due = {visits_due, v};
            if (beyond)
                break;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        visit_t want;
        if (!rst_n)
        begin
            side_units = grw_pkg::CELL_SIZE_RST;
            across     = grw_pkg::CELLS_ACROSS_RST;
            down       = grw_pkg::CELLS_DOWN_RST;
            visits_due.delete();
            fail_count = 0;
            cells_due  = 0;
            cells_seen = 0;
            walks_seen = 0;
        end
        else
        begin
            // track register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    grw_pkg::REG_CELL_SIZE:    side_units = pwdata[grw_pkg::CSW-1:0];
                    grw_pkg::REG_CELLS_ACROSS: across     = pwdata[grw_pkg::CNW-1:0];
                    grw_pkg::REG_CELLS_DOWN:   down       = pwdata[grw_pkg::CNW-1:0];
                    default: ;
                endcase
            end
            // compare the cell item with the oldest due
            if (visit.valid && visit.ready)
            begin
                cells_seen++;
                if (visits_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected cell idx=%0d in_grid=%0b last=%0b", $time,
                             visit.cell_index, visit.in_grid, visit.last);
                end
                else
                begin
                    want = visits_due.pop_front();
                    if (visit.cell_index !== want.idx || visit.in_grid !== want.on_grid
                        || visit.last !== want.fin)
                    begin
                        fail_count++;
                        $display("%0t: cell mismatch expected idx=%0d in=%0b last=%0b,",
                                 $time, want.idx, want.on_grid, want.fin,
                                 " got idx=%0d in=%0b last=%0b",
                                 visit.cell_index, visit.in_grid, visit.last);
                    end
                end
            end
            if (seg.valid && seg.ready)
            begin
                walks_seen++;
                plan_walk(longint'(seg.start_x), longint'(seg.start_z),
                          longint'(seg.end_x), longint'(seg.end_z));
            end
            cells_due = visits_due.size();
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives segments and register writes into the grid walker with random gaps
// and output stalls; the checker predicts and compares every cell item.
// ----------------------------------------------------------------------------
module tb_top;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [grw_pkg::APB_AW-1:0] paddr;
    logic [grw_pkg::APB_DW-1:0] pwdata;
    logic [grw_pkg::APB_DW-1:0] prdata;
    logic pready;
    int fail_count, cells_due, cells_seen, walks_seen;
    int cycles;
    bit hold_off;

    grw_seg_if  seg();
    grw_cell_if visit();

    grid_ray_cell_walk_top dut (
        .clk(clk), .rst_n(rst_n), .seg(seg), .visit(visit),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    grw_walk_checker chk (
        .clk(clk), .rst_n(rst_n), .seg(seg), .visit(visit),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .fail_count(fail_count),
        .cells_due(cells_due), .cells_seen(cells_seen), .walks_seen(walks_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int n;
        visit.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                visit.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            n = gap_len();
            if (n == 0)
                visit.ready <= 1'b1;
            else
            begin
                visit.ready <= 1'b0;
                repeat (n - 1) @(posedge clk);
            end
        end
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 1000000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic reg_write(logic [1:0] which, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one segment, then idle for a random gap
    task automatic send_seg(logic [31:0] sx, logic [31:0] sz, logic [31:0] ex,
                            logic [31:0] ez);
        int n;
        seg.valid   <= 1'b1;
        seg.start_x <= sx;
        seg.start_z <= sz;
        seg.end_x   <= ex;
        seg.end_z   <= ez;
        @(posedge clk);
        while (!seg.ready)
            @(posedge clk);
        n = gap_len();
        if (n > 0)
        begin
            seg.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Drop the input, wait until every due cell has come, then let the block settle
    task automatic drain();
        seg.valid <= 1'b0;
        @(posedge clk);
        while (cells_due != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // Mostly short walks near the start point, a few wild ones
    task automatic random_seg(int side_q8);
        logic [31:0] sx, sz;
        int span;
        if ($urandom_range(0, 9) == 0)
            send_seg($urandom, $urandom, $urandom, $urandom);
        else
        begin
            sx = $urandom_range(0, 70 * side_q8) - 3 * side_q8;
            sz = $urandom_range(0, 70 * side_q8) - 3 * side_q8;
            if ($urandom_range(0, 3) == 0)
            begin
                sx = sx - (sx % side_q8);
                sz = sz - (sz % side_q8);
            end
            span = $urandom_range(1, 8) * side_q8;
            send_seg(sx, sz, sx + $urandom_range(0, 2 * span) - span,
                     sz + $urandom_range(0, 2 * span) - span);
        end
    endtask

    initial
    begin
        int sq;
        cycles = 0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        seg.valid = 1'b0;
        seg.start_x = '0; seg.start_z = '0; seg.end_x = '0; seg.end_z = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset registers
        send_seg(32'd100, 32'd100, 32'd100, 32'd100);
        send_seg(32'd1000, 32'd2000, 32'd900000, 32'd2000);
        send_seg(32'd1000, 32'd1000, 32'd3000000, 32'd3000000);
        send_seg(32'd1048576, 32'd1048576, -32'd2000000, -32'd5);
        send_seg(32'd0, 32'd0, -32'd1, 32'd0);
        send_seg(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
        send_seg(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_seg(-32'd5000, 32'd0, -32'd5000, 32'd9000000);
        send_seg(32'd2048, 32'd2048, 32'd2048 + 32'd8000000, 32'd2048 + 32'd8000000);
        drain();

        // directed: extremes of the registers
        reg_write(grw_pkg::REG_CELL_SIZE, 32'd1);
        reg_write(grw_pkg::REG_CELLS_ACROSS, 32'd1024);
        reg_write(grw_pkg::REG_CELLS_DOWN, 32'd1024);
        send_seg(32'd0, 32'd0, 32'd5000, 32'd3000);
        send_seg(32'd262143, 32'd262143, 32'd261000, 32'd262500);
        send_seg(-32'd300, 32'd10, 32'd600, -32'd700);
        drain();
        reg_write(grw_pkg::REG_CELL_SIZE, 32'd65535);
        reg_write(grw_pkg::REG_CELLS_ACROSS, 32'd1);
        reg_write(grw_pkg::REG_CELLS_DOWN, 32'd1);
        send_seg(32'd0, 32'd0, 32'h7fffffff, 32'h7fffffff);
        send_seg(32'h80000000, 32'd5, 32'h7fffffff, 32'd6);
        drain();
        reg_write(grw_pkg::REG_CELL_SIZE, 32'd0);
        reg_write(grw_pkg::REG_CELLS_ACROSS, 32'd2047);
        send_seg(32'd0, 32'd0, 32'd2000, 32'd900);
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: sq = 16;
                1: sq = 1;
                2: sq = 200;
                default: sq = $urandom_range(1, 4000);
            endcase
            reg_write(grw_pkg::REG_CELL_SIZE, sq);
            reg_write(grw_pkg::REG_CELLS_ACROSS, $urandom_range(1, 1024));
            reg_write(grw_pkg::REG_CELLS_DOWN, $urandom_range(1, 1024));
            if (ph == 1)
                hold_off = 1'b1;
            for (int i = 0; i < 25; i++)
                random_seg(sq * 256);
            drain();
        end

        $display("Ran %0d segments, %0d cells checked across eight register settings",
                 walks_seen, cells_seen);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
